// ----- src/hht_pkg.sv -----
// ----------------------------------------------------------------------------
// HTTP header tokenizer package
// Parser phases, result codes, character constants and shared record types.
// ----------------------------------------------------------------------------
package hht_pkg;

    typedef enum logic [15:0] {
        PH_START  = 16'h0001,
        PH_METHOD = 16'h0002,
        PH_RSP1   = 16'h0004,
        PH_URI    = 16'h0008,
        PH_RSP2   = 16'h0010,
        PH_RVER   = 16'h0020,
        PH_REST   = 16'h0040,
        PH_SVER   = 16'h0080,
        PH_SSP1   = 16'h0100,
        PH_CODE   = 16'h0200,
        PH_SSP2   = 16'h0400,
        PH_REASON = 16'h0800,
        PH_NAME   = 16'h1000,
        PH_VSKIP  = 16'h2000,
        PH_VALUE  = 16'h4000,
        PH_IGNORE = 16'h8000
    } phase_t;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    localparam logic [2:0] FLD_METHOD  = 3'd0;
    localparam logic [2:0] FLD_URI     = 3'd1;
    localparam logic [2:0] FLD_VERSION = 3'd2;
    localparam logic [2:0] FLD_REASON  = 3'd3;
    localparam logic [2:0] FLD_NAME    = 3'd4;
    localparam logic [2:0] FLD_VALUE   = 3'd5;

    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_COLON = 8'h3a;
    localparam logic [7:0] CHAR_SP    = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_VT    = 8'h0b;
    localparam logic [7:0] CHAR_FF    = 8'h0c;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UZ    = 8'h5a;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    localparam logic [30:0] CODE_MAX = 31'h7fff_ffff;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] field_id;
        logic [7:0] token_byte;
        logic       keep;
    } res_t;

    typedef struct packed {
        phase_t      phase;
        logic        expect_lf;
        logic        tok_ne;
        logic [30:0] code;
        logic        code_seen;
        logic        failed;
    } pstate_t;

    typedef struct packed {
        logic [1:0]     count;
        res_t [2:0]     res;
        logic           parse_ok;
        logic           code_valid;
        logic [30:0]    resp_code;
    } step_out_t;

    function automatic res_t mk_res(logic [1:0] kind, logic [2:0] fid,
                                    logic [7:0] b, logic keep);
        res_t r;
        r.kind       = kind;
        r.field_id   = fid;
        r.token_byte = b;
        r.keep       = keep;
        return r;
    endfunction

endpackage

// ----- src/hht_step.sv -----
// ----------------------------------------------------------------------------
// HTTP header tokenizer step logic
// Next parser state and up to three results for one payload byte.
// ----------------------------------------------------------------------------
module hht_step (
    input  logic [7:0]          byte_in,
    input  logic                end_of_payload,
    input  logic                request_mode,
    input  hht_pkg::pstate_t    st,
    output hht_pkg::pstate_t    st_next,
    output hht_pkg::step_out_t  step_out
);
    import hht_pkg::*;

    logic        eol;
    logic        ws;
    logic        dig;
    logic        colon;
    logic [34:0] prod;
    logic [30:0] code_sat;
    logic [7:0]  lc_byte;

    assign eol   = (byte_in == CHAR_CR) || (byte_in == CHAR_LF);
    assign ws    = (byte_in == CHAR_SP) || (byte_in == CHAR_TAB) ||
                   (byte_in == CHAR_VT) || (byte_in == CHAR_FF);
    assign dig   = (byte_in >= CHAR_0) && (byte_in <= CHAR_9);
    assign colon = (byte_in == CHAR_COLON);

    // code * 10 + digit, saturate at the 31-bit limit
    assign prod = ({4'b0, st.code} << 3) + ({4'b0, st.code} << 1) +
                  {31'b0, byte_in[3:0]};
    assign code_sat = (prod > {4'b0, CODE_MAX}) ? CODE_MAX : prod[30:0];

    assign lc_byte = ((byte_in >= CHAR_UA) && (byte_in <= CHAR_UZ)) ?
                     (byte_in | CASE_BIT) : byte_in;

    always_comb begin
        pstate_t    s;
        res_t [2:0] res;
        logic [1:0] n;
        logic [2:0] fld;
        logic       skip;

        s    = st;
        res  = '0;
        n    = 2'd0;
        fld  = FLD_VERSION;
        skip = 1'b0;

        if (s.expect_lf) begin
            s.expect_lf = 1'b0;
            skip = (byte_in == CHAR_LF);
        end

        if (!skip) begin
            case (st.phase)
                PH_START: begin
                    if (eol || (request_mode && ws)) begin
                        s.failed = 1'b1;
                        s.phase  = PH_IGNORE;
                    end else if (request_mode) begin
                        res[n] = mk_res(KIND_BYTE, FLD_METHOD, byte_in, 1'b0);
                        n = n + 2'd1;
                        s.tok_ne = 1'b1;
                        s.phase  = PH_METHOD;
                    end else if (ws) begin
                        s.phase = PH_SSP1;
                    end else begin
                        res[n] = mk_res(KIND_BYTE, FLD_VERSION, byte_in, 1'b0);
                        n = n + 2'd1;
                        s.tok_ne = 1'b1;
                        s.phase  = PH_SVER;
                    end
                end
                PH_METHOD, PH_URI, PH_RVER, PH_SVER, PH_REASON: begin
                    if (st.phase == PH_METHOD) begin
                        fld = FLD_METHOD;
                    end else if (st.phase == PH_URI) begin
                        fld = FLD_URI;
                    end else if (st.phase == PH_REASON) begin
                        fld = FLD_REASON;
                    end
                    if (eol || ws) begin
                        if (s.tok_ne) begin
                            res[n] = mk_res(KIND_END, fld, 8'd0, 1'b1);
                            n = n + 2'd1;
                        end
                        s.tok_ne = 1'b0;
                        if (eol) begin
                            s.phase     = PH_NAME;
                            s.expect_lf = (byte_in == CHAR_CR);
                        end else if (st.phase == PH_METHOD) begin
                            s.phase = PH_RSP1;
                        end else if (st.phase == PH_URI) begin
                            s.phase = PH_RSP2;
                        end else if (st.phase == PH_SVER) begin
                            s.phase = PH_SSP1;
                        end else begin
                            s.phase = PH_REST;
                        end
                    end else begin
                        res[n] = mk_res(KIND_BYTE, fld, byte_in, 1'b0);
                        n = n + 2'd1;
                        s.tok_ne = 1'b1;
                    end
                end
                PH_RSP1, PH_RSP2: begin
                    if (eol) begin
                        s.phase     = PH_NAME;
                        s.tok_ne    = 1'b0;
                        s.expect_lf = (byte_in == CHAR_CR);
                    end else if (!ws) begin
                        fld = (st.phase == PH_RSP1) ? FLD_URI : FLD_VERSION;
                        res[n] = mk_res(KIND_BYTE, fld, byte_in, 1'b0);
                        n = n + 2'd1;
                        s.tok_ne = 1'b1;
                        s.phase  = (st.phase == PH_RSP1) ? PH_URI : PH_RVER;
                    end
                end
                PH_SSP1, PH_CODE: begin
                    if (eol) begin
                        s.phase     = PH_NAME;
                        s.tok_ne    = 1'b0;
                        s.expect_lf = (byte_in == CHAR_CR);
                    end else if (dig) begin
                        s.code      = code_sat;
                        s.code_seen = 1'b1;
                        s.phase     = PH_CODE;
                    end else if (ws) begin
                        s.phase = (st.phase == PH_CODE) ? PH_SSP2 : PH_SSP1;
                    end else begin
                        res[n] = mk_res(KIND_BYTE, FLD_REASON, byte_in, 1'b0);
                        n = n + 2'd1;
                        s.tok_ne = 1'b1;
                        s.phase  = PH_REASON;
                    end
                end
                PH_SSP2: begin
                    if (eol) begin
                        s.phase     = PH_NAME;
                        s.tok_ne    = 1'b0;
                        s.expect_lf = (byte_in == CHAR_CR);
                    end else if (!ws) begin
                        res[n] = mk_res(KIND_BYTE, FLD_REASON, byte_in, 1'b0);
                        n = n + 2'd1;
                        s.tok_ne = 1'b1;
                        s.phase  = PH_REASON;
                    end
                end
                PH_REST: begin
                    if (eol) begin
                        s.phase     = PH_NAME;
                        s.tok_ne    = 1'b0;
                        s.expect_lf = (byte_in == CHAR_CR);
                    end
                end
                PH_NAME: begin
                    if (eol) begin
                        // empty line closes the header block
                        if (!s.tok_ne) begin
                            s.phase = PH_IGNORE;
                        end else begin
                            res[n] = mk_res(KIND_END, FLD_NAME, 8'd0, 1'b0);
                            n = n + 2'd1;
                            s.phase     = PH_NAME;
                            s.tok_ne    = 1'b0;
                            s.expect_lf = (byte_in == CHAR_CR);
                        end
                    end else if (colon) begin
                        res[n] = mk_res(KIND_END, FLD_NAME, 8'd0, 1'b1);
                        n = n + 2'd1;
                        s.tok_ne = 1'b0;
                        s.phase  = PH_VSKIP;
                    end else begin
                        res[n] = mk_res(KIND_BYTE, FLD_NAME, lc_byte, 1'b0);
                        n = n + 2'd1;
                        s.tok_ne = 1'b1;
                    end
                end
                PH_VSKIP, PH_VALUE: begin
                    if (eol) begin
                        res[n] = mk_res(KIND_END, FLD_VALUE, 8'd0, 1'b1);
                        n = n + 2'd1;
                        s.phase     = PH_NAME;
                        s.tok_ne    = 1'b0;
                        s.expect_lf = (byte_in == CHAR_CR);
                    end else if (!(ws && (st.phase == PH_VSKIP))) begin
                        res[n] = mk_res(KIND_BYTE, FLD_VALUE, byte_in, 1'b0);
                        n = n + 2'd1;
                        s.phase = PH_VALUE;
                    end
                end
                default: begin
                end
            endcase
        end

        step_out.parse_ok   = 1'b0;
        step_out.code_valid = 1'b0;
        step_out.resp_code  = '0;

        if (end_of_payload) begin
            // close whatever token is still open, then report done
            case (s.phase)
                PH_METHOD: begin
                    if (s.tok_ne) begin
                        res[n] = mk_res(KIND_END, FLD_METHOD, 8'd0, 1'b1);
                        n = n + 2'd1;
                    end
                end
                PH_URI: begin
                    if (s.tok_ne) begin
                        res[n] = mk_res(KIND_END, FLD_URI, 8'd0, 1'b1);
                        n = n + 2'd1;
                    end
                end
                PH_RVER, PH_SVER: begin
                    if (s.tok_ne) begin
                        res[n] = mk_res(KIND_END, FLD_VERSION, 8'd0, 1'b1);
                        n = n + 2'd1;
                    end
                end
                PH_REASON: begin
                    if (s.tok_ne) begin
                        res[n] = mk_res(KIND_END, FLD_REASON, 8'd0, 1'b1);
                        n = n + 2'd1;
                    end
                end
                PH_NAME: begin
                    if (s.tok_ne) begin
                        res[n] = mk_res(KIND_END, FLD_NAME, 8'd0, 1'b0);
                        n = n + 2'd1;
                    end
                end
                PH_VSKIP, PH_VALUE: begin
                    res[n] = mk_res(KIND_END, FLD_VALUE, 8'd0, 1'b1);
                    n = n + 2'd1;
                end
                default: begin
                end
            endcase
            res[n] = mk_res(KIND_DONE, FLD_METHOD, 8'd0, 1'b0);
            n = n + 2'd1;
            step_out.parse_ok   = !s.failed;
            step_out.code_valid = s.code_seen;
            step_out.resp_code  = s.code;
            s.phase     = PH_START;
            s.expect_lf = 1'b0;
            s.tok_ne    = 1'b0;
            s.code      = '0;
            s.code_seen = 1'b0;
            s.failed    = 1'b0;
        end

        st_next        = s;
        step_out.count = n;
        step_out.res   = res;
    end

endmodule

// ----- src/http_header_tokenizer_top.sv -----
// ----------------------------------------------------------------------------
// HTTP header tokenizer
// Splits an HTTP/1.x start line and header lines into token results.
// ----------------------------------------------------------------------------
// Accepts one payload byte per clock while the result buffer can take it. Each
// byte is registered, decoded combinationally into zero to three results and
// moved into a three-entry result buffer that feeds the single result port.
// The next byte is decoded once the buffer has drained, so a byte that yields
// several results holds off the following byte until they have all left. The
// input byte register and then the result buffer lie before the first result.
// request_mode selects a request line (1) or a status line (0); write it only between payloads.
module http_header_tokenizer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_request_mode,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    input  logic        s_end_of_payload,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [2:0]  m_field_id,
    output logic [7:0]  m_token_byte,
    output logic        m_keep,
    output logic        m_parse_ok,
    output logic        m_code_valid,
    output logic [30:0] m_resp_code,
    output logic        m_last_result
);
    import hht_pkg::*;

    logic        request_mode_reg;
    logic        in_vld_reg;
    logic [7:0]  in_byte_reg;
    logic        in_eop_reg;
    pstate_t     st_reg;
    pstate_t     st_next;
    step_out_t   step_out;
    res_t        res_reg [3];
    logic [1:0]  cnt_reg;
    logic [1:0]  rd_reg;
    logic        ok_reg;
    logic        cv_reg;
    logic [30:0] code_reg;
    res_t        head;
    logic        head_last;
    logic        buf_free;
    logic        in_consume;

    hht_step u_step (
        .byte_in        (in_byte_reg),
        .end_of_payload (in_eop_reg),
        .request_mode   (request_mode_reg),
        .st             (st_reg),
        .st_next        (st_next),
        .step_out       (step_out)
    );

    assign cfg_ready = 1'b1;

    assign head      = res_reg[rd_reg];
    assign head_last = (rd_reg == (cnt_reg - 2'd1));
    assign m_valid   = (cnt_reg != 2'd0);

    // buffer is free when empty or when its last result leaves this cycle
    assign buf_free   = !m_valid || (m_ready && head_last);
    assign in_consume = in_vld_reg && buf_free;
    assign s_ready    = !in_vld_reg || buf_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            request_mode_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            request_mode_reg <= cfg_request_mode;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_vld_reg <= 1'b1;
        end else if (in_consume) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_byte_in;
            in_eop_reg  <= s_end_of_payload;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.phase     <= PH_START;
            st_reg.expect_lf <= 1'b0;
            st_reg.tok_ne    <= 1'b0;
            st_reg.code      <= '0;
            st_reg.code_seen <= 1'b0;
            st_reg.failed    <= 1'b0;
        end else if (in_consume) begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            rd_reg  <= 2'd0;
        end else if (in_consume) begin
            cnt_reg <= step_out.count;
            rd_reg  <= 2'd0;
        end else if (m_valid && m_ready) begin
            if (head_last) begin
                cnt_reg <= 2'd0;
                rd_reg  <= 2'd0;
            end else begin
                rd_reg <= rd_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_consume) begin
            res_reg[0] <= step_out.res[0];
            res_reg[1] <= step_out.res[1];
            res_reg[2] <= step_out.res[2];
            ok_reg     <= step_out.parse_ok;
            cv_reg     <= step_out.code_valid;
            code_reg   <= step_out.resp_code;
        end
    end

    assign m_kind        = head.kind;
    assign m_field_id    = head.field_id;
    assign m_token_byte  = head.token_byte;
    assign m_keep        = head.keep;
    assign m_parse_ok    = (head.kind == KIND_DONE) ? ok_reg : 1'b0;
    assign m_code_valid  = (head.kind == KIND_DONE) ? cv_reg : 1'b0;
    assign m_resp_code   = (head.kind == KIND_DONE) ? code_reg : '0;
    assign m_last_result = head_last;

`ifndef SYNTHESIS
    a_rd_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (rd_reg < cnt_reg))
        else $error("result read pointer beyond fill count");

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind == KIND_DONE)) |-> m_last_result)
        else $error("done result is not the last of its request");

    a_eop_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_consume && in_eop_reg) |=>
            ((st_reg.phase == PH_START) && !st_reg.failed && !st_reg.code_seen))
        else $error("parser did not restart after end of payload");

    a_eop_gives_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_consume && in_eop_reg) |=> (m_valid && (cnt_reg != 2'd0)))
        else $error("end of payload produced no results");
`endif

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP header tokenizer testbench
// Streams request and status payloads through the byte port, predicts every
// token byte, token end and done result cycle-free, and checks the result
// stream field by field, mostly under random stalls on both ports.
// ----------------------------------------------------------------------------
module tb;
    import hht_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [7:0] data;
        logic       eop;
    } payload_byte_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  fld;
        logic [7:0]  data;
        logic        keep;
        logic        ok;
        logic        cv;
        logic [30:0] code;
        logic        last;
    } token_rec_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_request_mode = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_byte_in = 8'h00;
    logic        s_end_of_payload = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [2:0]  m_field_id;
    logic [7:0]  m_token_byte;
    logic        m_keep;
    logic        m_parse_ok;
    logic        m_code_valid;
    logic [30:0] m_resp_code;
    logic        m_last_result;

    payload_byte_t tx_bytes[$];
    token_rec_t    expected_tokens[$];
    token_rec_t    step_tokens[$];
    logic [7:0]    draft_q[$];

    int  errors = 0;
    int  cycles = 0;
    int  bytes_queued = 0;
    bit  no_gaps = 1'b0;

    // predictor state
    phase_t      cur_phase = PH_START;
    logic        lf_pending = 1'b0;
    logic        tok_open = 1'b0;
    logic [30:0] code_acc = '0;
    logic        code_hit = 1'b0;
    logic        broken = 1'b0;
    logic        mode_req = 1'b1;

    http_header_tokenizer_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_request_mode (cfg_request_mode),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_byte_in        (s_byte_in),
        .s_end_of_payload (s_end_of_payload),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_field_id       (m_field_id),
        .m_token_byte     (m_token_byte),
        .m_keep           (m_keep),
        .m_parse_ok       (m_parse_ok),
        .m_code_valid     (m_code_valid),
        .m_resp_code      (m_resp_code),
        .m_last_result    (m_last_result)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void clear_parse();
        cur_phase  = PH_START;
        lf_pending = 1'b0;
        tok_open   = 1'b0;
        code_acc   = '0;
        code_hit   = 1'b0;
        broken     = 1'b0;
    endfunction

    function automatic void add_token_rec(logic [1:0] kind, logic [2:0] fld,
                                          logic [7:0] data, logic keep);
        token_rec_t r;
        r      = '0;
        r.kind = kind;
        r.fld  = fld;
        r.data = data;
        r.keep = keep;
        step_tokens.push_back(r);
    endfunction

    function automatic logic [2:0] token_field(phase_t p);
        case (p)
            PH_METHOD: return FLD_METHOD;
            PH_URI:    return FLD_URI;
            PH_REASON: return FLD_REASON;
            default:   return FLD_VERSION;
        endcase
    endfunction

    function automatic void close_token(logic [2:0] fld);
        if (tok_open) add_token_rec(KIND_END, fld, 8'h00, 1'b1);
        tok_open = 1'b0;
    endfunction

    function automatic void open_token(logic [2:0] fld, logic [7:0] b, phase_t nxt);
        add_token_rec(KIND_BYTE, fld, b, 1'b0);
        tok_open  = 1'b1;
        cur_phase = nxt;
    endfunction

    function automatic void end_line(logic [7:0] b);
        cur_phase  = PH_NAME;
        tok_open   = 1'b0;
        lf_pending = (b == CHAR_CR);
    endfunction

    function automatic void tokenize_byte(logic [7:0] b, logic eop);
        logic            eol;
        logic            ws;
        logic            dig;
        logic            skip;
        logic [7:0]      c;
        longint unsigned acc;
        token_rec_t      r;
        eol  = (b == CHAR_CR) || (b == CHAR_LF);
        ws   = (b == CHAR_SP) || (b == CHAR_TAB) || (b == CHAR_VT) || (b == CHAR_FF);
        dig  = (b >= CHAR_0) && (b <= CHAR_9);
        skip = 1'b0;
        step_tokens.delete();

        // LF right after CR belongs to the same line end
        if (lf_pending) begin
            lf_pending = 1'b0;
            skip = (b == CHAR_LF);
        end

        if (!skip) begin
            case (cur_phase)
                PH_START: begin
                    if (eol || (mode_req && ws)) begin
                        broken    = 1'b1;
                        cur_phase = PH_IGNORE;
                    end else if (mode_req) begin
                        open_token(FLD_METHOD, b, PH_METHOD);
                    end else if (ws) begin
                        cur_phase = PH_SSP1;
                    end else begin
                        open_token(FLD_VERSION, b, PH_SVER);
                    end
                end
                PH_METHOD, PH_URI, PH_RVER, PH_SVER, PH_REASON: begin
                    if (eol) begin
                        close_token(token_field(cur_phase));
                        end_line(b);
                    end else if (ws) begin
                        close_token(token_field(cur_phase));
                        case (cur_phase)
                            PH_METHOD: cur_phase = PH_RSP1;
                            PH_URI:    cur_phase = PH_RSP2;
                            PH_SVER:   cur_phase = PH_SSP1;
                            default:   cur_phase = PH_REST;
                        endcase
                    end else begin
                        add_token_rec(KIND_BYTE, token_field(cur_phase), b, 1'b0);
                        tok_open = 1'b1;
                    end
                end
                PH_RSP1, PH_RSP2: begin
                    if (eol) begin
                        end_line(b);
                    end else if (!ws) begin
                        if (cur_phase == PH_RSP1) open_token(FLD_URI, b, PH_URI);
                        else open_token(FLD_VERSION, b, PH_RVER);
                    end
                end
                PH_SSP1, PH_CODE: begin
                    if (eol) begin
                        end_line(b);
                    end else if (dig) begin
                        acc      = 64'(code_acc) * 64'd10 + 64'(b - CHAR_0);
                        code_acc = (acc > 64'(CODE_MAX)) ? CODE_MAX : acc[30:0];
                        code_hit = 1'b1;
                        cur_phase = PH_CODE;
                    end else if (ws) begin
                        if (cur_phase == PH_CODE) cur_phase = PH_SSP2;
                    end else begin
                        open_token(FLD_REASON, b, PH_REASON);
                    end
                end
                PH_SSP2: begin
                    if (eol) end_line(b);
                    else if (!ws) open_token(FLD_REASON, b, PH_REASON);
                end
                PH_REST: begin
                    if (eol) end_line(b);
                end
                PH_NAME: begin
                    if (eol) begin
                        // empty line closes the header block
                        if (!tok_open) begin
                            cur_phase = PH_IGNORE;
                        end else begin
                            add_token_rec(KIND_END, FLD_NAME, 8'h00, 1'b0);
                            end_line(b);
                        end
                    end else if (b == CHAR_COLON) begin
                        add_token_rec(KIND_END, FLD_NAME, 8'h00, 1'b1);
                        tok_open  = 1'b0;
                        cur_phase = PH_VSKIP;
                    end else begin
                        c = (b >= CHAR_UA && b <= CHAR_UZ) ? (b | CASE_BIT) : b;
                        add_token_rec(KIND_BYTE, FLD_NAME, c, 1'b0);
                        tok_open = 1'b1;
                    end
                end
                PH_VSKIP, PH_VALUE: begin
                    if (eol) begin
                        add_token_rec(KIND_END, FLD_VALUE, 8'h00, 1'b1);
                        end_line(b);
                    end else if (!(ws && cur_phase == PH_VSKIP)) begin
                        add_token_rec(KIND_BYTE, FLD_VALUE, b, 1'b0);
                        cur_phase = PH_VALUE;
                    end
                end
                default: ;
            endcase
        end

        if (eop) begin
            case (cur_phase)
                PH_METHOD, PH_URI, PH_RVER, PH_SVER, PH_REASON:
                    close_token(token_field(cur_phase));
                PH_NAME:
                    if (tok_open) add_token_rec(KIND_END, FLD_NAME, 8'h00, 1'b0);
                PH_VSKIP, PH_VALUE:
                    add_token_rec(KIND_END, FLD_VALUE, 8'h00, 1'b1);
                default: ;
            endcase
            r      = '0;
            r.kind = KIND_DONE;
            r.ok   = !broken;
            r.cv   = code_hit;
            r.code = code_acc;
            step_tokens.push_back(r);
            clear_parse();
        end

        if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Driver, sink and monitor
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : byte_driver
        payload_byte_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (tx_bytes.size() > 0 && (no_gaps || $urandom_range(0, 99) >= 20)) begin
                nxt = tx_bytes.pop_front();
                s_valid          <= 1'b1;
                s_byte_in        <= nxt.data;
                s_end_of_payload <= nxt.eop;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= no_gaps || ($urandom_range(0, 99) >= 20);
    end

    function automatic void check_field(string name, logic [30:0] want, logic [30:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin : result_monitor
        token_rec_t e;
        if (!aresetn) begin
            clear_parse();
            mode_req = 1'b1;
            expected_tokens.delete();
        end else begin
            if (cfg_valid && cfg_ready) mode_req = cfg_request_mode;
            if (s_valid && s_ready) tokenize_byte(s_byte_in, s_end_of_payload);
            if (m_valid && m_ready) begin
                if (expected_tokens.size() == 0) begin
                    $error("result with nothing expected: kind %0h field %0h byte %0h",
                           m_kind, m_field_id, m_token_byte);
                    errors++;
                end else begin
                    e = expected_tokens.pop_front();
                    check_field("kind", e.kind, m_kind);
                    check_field("field_id", e.fld, m_field_id);
                    check_field("token_byte", e.data, m_token_byte);
                    check_field("keep", e.keep, m_keep);
                    check_field("parse_ok", e.ok, m_parse_ok);
                    check_field("code_valid", e.cv, m_code_valid);
                    check_field("resp_code", e.code, m_resp_code);
                    check_field("last_result", e.last, m_last_result);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic void push_byte(logic [7:0] data, logic eop = 1'b0);
        payload_byte_t p;
        p.data = data;
        p.eop  = eop;
        tx_bytes.push_back(p);
        bytes_queued++;
    endfunction

    function automatic void push_text(string s, logic eop = 1'b0);
        for (int i = 0; i < s.len(); i++) push_byte(s[i], eop && (i == s.len() - 1));
    endfunction

    function automatic logic [7:0] ws_char();
        case ($urandom_range(0, 3))
            0:       return CHAR_TAB;
            1:       return CHAR_VT;
            2:       return CHAR_FF;
            default: return CHAR_SP;
        endcase
    endfunction

    function automatic logic [7:0] tok_char();
        int r;
        r = $urandom_range(0, 11);
        if (r == 0) return 8'($urandom_range(0, 255));
        if (r <= 3) return CHAR_UA + 8'($urandom_range(0, 25));
        return 8'($urandom_range(8'h21, 8'h7e));
    endfunction

    function automatic void add_token(int len);
        repeat (len) draft_q.push_back(tok_char());
    endfunction

    function automatic void add_spaces(int lo, int hi);
        repeat ($urandom_range(lo, hi)) draft_q.push_back(ws_char());
    endfunction

    function automatic void add_eol();
        case ($urandom_range(0, 3))
            0: draft_q.push_back(CHAR_LF);
            1: draft_q.push_back(CHAR_CR);
            default: begin
                draft_q.push_back(CHAR_CR);
                draft_q.push_back(CHAR_LF);
            end
        endcase
    endfunction

    // Mostly well-formed payloads with random content; some noise and truncation.
    function automatic void queue_payload(logic rq);
        int cut;
        draft_q.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 8)) draft_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            if (rq) begin
                add_token($urandom_range(1, 4));
                add_spaces(1, 2);
                add_token($urandom_range(0, 4));
                add_spaces(1, 2);
                add_token($urandom_range(0, 3));
                if ($urandom_range(0, 3) == 0) begin
                    add_spaces(1, 2);
                    add_token($urandom_range(1, 2));
                end
            end else begin
                add_token($urandom_range(0, 3));
                add_spaces(1, 2);
                repeat (($urandom_range(0, 3) == 0) ? 12 : $urandom_range(0, 3))
                    draft_q.push_back(CHAR_0 + 8'($urandom_range(0, 9)));
                add_spaces(0, 2);
                add_token($urandom_range(0, 4));
            end
            add_eol();
            repeat ($urandom_range(0, 3)) begin
                add_token($urandom_range(0, 4));
                if ($urandom_range(0, 6) != 0) begin
                    draft_q.push_back(CHAR_COLON);
                    add_spaces(0, 2);
                    repeat ($urandom_range(0, 5))
                        draft_q.push_back(($urandom_range(0, 4) == 0) ? ws_char() : tok_char());
                end
                add_eol();
            end
            if ($urandom_range(0, 1) == 1) begin
                add_eol();
                add_token($urandom_range(0, 3));
            end
            if ($urandom_range(0, 4) == 0 && draft_q.size() > 0) begin
                cut = $urandom_range(1, draft_q.size());
                while (draft_q.size() > cut) void'(draft_q.pop_back());
            end
        end
        if (draft_q.size() == 0) draft_q.push_back(tok_char());
        foreach (draft_q[i]) push_byte(draft_q[i], i == draft_q.size() - 1);
    endfunction

    task automatic write_mode(logic rq);
        @(posedge aclk);
        cfg_valid        <= 1'b1;
        cfg_request_mode <= rq;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        while (tx_bytes.size() != 0 || s_valid || expected_tokens.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        int target;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // request lines: empty first line, leading whitespace, full header block
        write_mode(1'b1);
        push_byte(CHAR_CR, 1'b1);
        push_byte(CHAR_SP);
        push_text("x", 1'b1);
        push_text("M");
        push_byte(8'hff);
        push_text(" u v x");
        push_byte(CHAR_CR);
        push_text("AZ:");
        push_byte(CHAR_VT);
        push_byte(CHAR_FF);
        push_text("v");
        push_byte(CHAR_LF);
        push_text("k");
        push_byte(8'h00);
        push_byte(CHAR_CR);
        push_byte(CHAR_LF);
        push_byte(CHAR_CR);
        push_byte(CHAR_LF);
        push_text("z", 1'b1);
        settle();

        // status lines: empty first line, saturating code, value open at the end
        write_mode(1'b0);
        push_byte(CHAR_LF, 1'b1);
        push_text(" 99999999999 OK");
        push_byte(CHAR_LF);
        push_text("x:", 1'b1);
        settle();

        for (int i = 0; i < 4; i++) begin
            write_mode(i[0] ? 1'b0 : 1'b1);
            no_gaps = (i == 2);
            target = bytes_queued + ((i == 2) ? 16 : 4);
            while (bytes_queued < target) queue_payload(i[0] ? 1'b0 : 1'b1);
            settle();
        end
        no_gaps = 1'b0;

        if (errors == 0 && expected_tokens.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
